/* src/i2cm_pkg.sv */
`timescale 1ns / 1ps
// shared types, command and phase codes for the i2c master byte controller
// no dependencies

package i2cm_pkg;

    localparam int TIMER_BITS = 10;
    localparam int CFG_W      = 10;
    localparam int LOAD_W     = 17;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [LOAD_W-1:0]     TIMER_MAX = LOAD_W'((1 << TIMER_BITS) - 1);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    // commands
    localparam logic [2:0] CMD_NONE      = 3'd0;
    localparam logic [2:0] CMD_START     = 3'd1;
    localparam logic [2:0] CMD_RESTART   = 3'd2;
    localparam logic [2:0] CMD_STOP      = 3'd3;
    localparam logic [2:0] CMD_WRITE     = 3'd4;
    localparam logic [2:0] CMD_READ_ACK  = 3'd5;
    localparam logic [2:0] CMD_READ_NACK = 3'd6;

    // phases
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_STA_SETUP = 4'd1;
    localparam logic [3:0] PH_STA_SDA   = 4'd2;
    localparam logic [3:0] PH_STA_HOLD  = 4'd3;
    localparam logic [3:0] PH_RS_REL    = 4'd4;
    localparam logic [3:0] PH_STO_RISE  = 4'd5;
    localparam logic [3:0] PH_STO_SETUP = 4'd6;
    localparam logic [3:0] PH_BIT_LOW   = 4'd7;
    localparam logic [3:0] PH_BIT_RISE  = 4'd8;
    localparam logic [3:0] PH_BIT_HIGH  = 4'd9;

    // register indexes
    localparam logic [2:0] REG_SETUP_START = 3'd0;
    localparam logic [2:0] REG_HOLD_START  = 3'd1;
    localparam logic [2:0] REG_SETUP_STOP  = 3'd2;
    localparam logic [2:0] REG_CLOCK_LOW   = 3'd3;
    localparam logic [2:0] REG_CLOCK_HIGH  = 3'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [CFG_W-1:0] setup_start_ticks;
        logic [CFG_W-1:0] hold_start_ticks;
        logic [CFG_W-1:0] setup_stop_ticks;
        logic [CFG_W-1:0] clock_low_ticks;
        logic [CFG_W-1:0] clock_high_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0]            phase;
        logic [3:0]            bit_count;
        logic [7:0]            shift_reg;
        logic [TIMER_BITS-1:0] tick_timer;
        logic [2:0]            active_cmd;
        logic                  drv_sda;
        logic                  drv_scl;
        logic                  flag_arb;
        logic                  flag_nack;
        logic [7:0]            last_read;
    } ctrl_state_t;

endpackage

/* src/i2c_master_byte_controller.sv */
`timescale 1ns / 1ps
// i2c master byte controller: one bus tick per transaction, result data registered without reset
// throughput one tick every cycle while m_ready holds (s_ready drops while a held result
// is not taken), set by the single registered pass through the next-state logic
// reset: synchronous, active low; controller state idle, its line drives released, flags and read byte
// cleared, timing registers back to their defaults; depends on i2cm_pkg, i2cm_cfg, i2cm_step

module i2c_master_byte_controller import i2cm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [2:0]        s_command,
    input  logic [7:0]        s_write_byte,
    input  logic              s_scl_in,
    input  logic              s_sda_in,

    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_scl_pull_low,
    output logic              m_sda_pull_low,
    output logic              m_busy_res,
    output logic              m_done_res,
    output logic [7:0]        m_read_data,
    output logic              m_nack_received,
    output logic              m_arbitration_lost
);

    cfg_t        cfg;
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        done_next;
    logic        accept;

    logic        m_valid_reg;
    logic        scl_reg;
    logic        sda_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  rdata_reg;
    logic        nack_reg;
    logic        arb_reg;

    i2cm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    i2cm_step u_step (
        .cur        (state_reg),
        .cfg        (cfg),
        .command    (s_command),
        .write_byte (s_write_byte),
        .scl_in     (s_scl_in),
        .sda_in     (s_sda_in),
        .nxt        (state_next),
        .done       (done_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (accept) begin
            scl_reg   <= state_next.drv_scl;
            sda_reg   <= state_next.drv_sda;
            busy_reg  <= (state_next.phase != PH_IDLE);
            done_reg  <= done_next;
            rdata_reg <= state_next.last_read;
            nack_reg  <= state_next.flag_nack;
            arb_reg   <= state_next.flag_arb;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_scl_pull_low     = scl_reg;
    assign m_sda_pull_low     = sda_reg;
    assign m_busy_res         = busy_reg;
    assign m_done_res         = done_reg;
    assign m_read_data        = rdata_reg;
    assign m_nack_received    = nack_reg;
    assign m_arbitration_lost = arb_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_reg |-> !busy_reg)
        else $error("done reported while still busy");

    a_arb_releases: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && arb_reg |-> !scl_reg && !sda_reg)
        else $error("lines driven after arbitration loss");

    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_count <= BITS_PER_BYTE)
        else $error("bit counter out of range");

endmodule

/* src/i2cm_cfg.sv */
`timescale 1ns / 1ps
// apb register file holding the five timing registers
// depends on i2cm_pkg

module i2cm_cfg import i2cm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setup_start_ticks <= CFG_W'(47);
            cfg_reg.hold_start_ticks  <= CFG_W'(40);
            cfg_reg.setup_stop_ticks  <= CFG_W'(40);
            cfg_reg.clock_low_ticks   <= CFG_W'(47);
            cfg_reg.clock_high_ticks  <= CFG_W'(40);
        end else if (wr_en) begin
            unique case (reg_index)
                REG_SETUP_START: cfg_reg.setup_start_ticks <= pwdata[CFG_W-1:0];
                REG_HOLD_START:  cfg_reg.hold_start_ticks  <= pwdata[CFG_W-1:0];
                REG_SETUP_STOP:  cfg_reg.setup_stop_ticks  <= pwdata[CFG_W-1:0];
                REG_CLOCK_LOW:   cfg_reg.clock_low_ticks   <= pwdata[CFG_W-1:0];
                REG_CLOCK_HIGH:  cfg_reg.clock_high_ticks  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_SETUP_START: prdata = DATA_W'(cfg_reg.setup_start_ticks);
            REG_HOLD_START:  prdata = DATA_W'(cfg_reg.hold_start_ticks);
            REG_SETUP_STOP:  prdata = DATA_W'(cfg_reg.setup_stop_ticks);
            REG_CLOCK_LOW:   prdata = DATA_W'(cfg_reg.clock_low_ticks);
            REG_CLOCK_HIGH:  prdata = DATA_W'(cfg_reg.clock_high_ticks);
            default:         prdata = '0;
        endcase
    end

endmodule

/* src/i2cm_step.sv */
`timescale 1ns / 1ps
// next-state logic for one bus tick of the bit-level controller
// depends on i2cm_pkg

module i2cm_step import i2cm_pkg::*; (
    input  ctrl_state_t cur,
    input  cfg_t        cfg,
    input  logic [2:0]  command,
    input  logic [7:0]  write_byte,
    input  logic        scl_in,
    input  logic        sda_in,
    output ctrl_state_t nxt,
    output logic        done
);

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_W-1:0] ticks);
        logic [LOAD_W-1:0] v;
        v = (ticks == '0) ? '0 : (LOAD_W'(ticks) - LOAD_W'(1));
        if (v > TIMER_MAX) begin
            return TIMER_MAX[TIMER_BITS-1:0];
        end
        return v[TIMER_BITS-1:0];
    endfunction

    function automatic logic bit_sda_pull(input logic [2:0] cmd, input logic [3:0] cnt,
                                          input logic [7:0] sr);
        logic pull;
        pull = 1'b0;
        if (cmd == CMD_WRITE) begin
            if (cnt < BITS_PER_BYTE) begin
                pull = !sr[~cnt[2:0]];
            end
        end else if (cnt >= BITS_PER_BYTE) begin
            pull = (cmd == CMD_READ_ACK);
        end
        return pull;
    endfunction

    logic [3:0] cnt_inc;

    assign cnt_inc = cur.bit_count + 4'd1;

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        unique case (cur.phase)
            PH_IDLE: begin
                if (command >= CMD_START && command <= CMD_READ_NACK) begin
                    nxt.active_cmd = command;
                    nxt.flag_arb   = 1'b0;
                    nxt.flag_nack  = 1'b0;
                    unique case (command)
                        CMD_START: begin
                            nxt.drv_scl    = 1'b0;
                            nxt.drv_sda    = 1'b0;
                            nxt.tick_timer = timer_load(cfg.setup_start_ticks);
                            nxt.phase      = PH_STA_SETUP;
                        end
                        CMD_RESTART: begin
                            nxt.drv_scl = 1'b0;
                            nxt.drv_sda = 1'b0;
                            nxt.phase   = PH_RS_REL;
                        end
                        CMD_STOP: begin
                            nxt.drv_scl = 1'b0;
                            nxt.drv_sda = 1'b1;
                            nxt.phase   = PH_STO_RISE;
                        end
                        default: begin
                            nxt.shift_reg  = (command == CMD_WRITE) ? write_byte : 8'd0;
                            nxt.bit_count  = 4'd0;
                            nxt.drv_scl    = 1'b1;
                            nxt.drv_sda    = bit_sda_pull(command, 4'd0,
                                                 (command == CMD_WRITE) ? write_byte : 8'd0);
                            nxt.tick_timer = timer_load(cfg.clock_low_ticks);
                            nxt.phase      = PH_BIT_LOW;
                        end
                    endcase
                end
            end
            PH_RS_REL: begin
                if (scl_in) begin
                    nxt.tick_timer = timer_load(cfg.setup_start_ticks);
                    nxt.phase      = PH_STA_SETUP;
                end
            end
            PH_STA_SETUP: begin
                if (cur.tick_timer == '0) begin
                    nxt.drv_scl = 1'b0;
                    nxt.drv_sda = 1'b1;
                    nxt.phase   = PH_STA_SDA;
                end else begin
                    nxt.tick_timer = cur.tick_timer - TIMER_ONE;
                end
            end
            PH_STA_SDA: begin
                if (!sda_in) begin
                    nxt.tick_timer = timer_load(cfg.hold_start_ticks);
                    nxt.phase      = PH_STA_HOLD;
                end
            end
            PH_STA_HOLD: begin
                if (cur.tick_timer == '0) begin
                    nxt.drv_scl = 1'b1;
                    nxt.drv_sda = 1'b1;
                    nxt.phase   = PH_IDLE;
                    done        = 1'b1;
                end else begin
                    nxt.tick_timer = cur.tick_timer - TIMER_ONE;
                end
            end
            PH_STO_RISE: begin
                if (!sda_in && scl_in) begin
                    nxt.tick_timer = timer_load(cfg.setup_stop_ticks);
                    nxt.phase      = PH_STO_SETUP;
                end
            end
            PH_STO_SETUP: begin
                if (cur.tick_timer == '0) begin
                    nxt.drv_scl = 1'b0;
                    nxt.drv_sda = 1'b0;
                    nxt.phase   = PH_IDLE;
                    done        = 1'b1;
                end else begin
                    nxt.tick_timer = cur.tick_timer - TIMER_ONE;
                end
            end
            PH_BIT_LOW: begin
                if (cur.tick_timer == '0) begin
                    nxt.drv_scl = 1'b0;
                    nxt.phase   = PH_BIT_RISE;
                end else begin
                    nxt.tick_timer = cur.tick_timer - TIMER_ONE;
                end
            end
            PH_BIT_RISE: begin
                if (scl_in) begin
                    if (cur.active_cmd == CMD_WRITE) begin
                        if (cur.bit_count < BITS_PER_BYTE) begin
                            if (cur.shift_reg[~cur.bit_count[2:0]] && !sda_in) begin
                                nxt.flag_arb = 1'b1;
                                nxt.drv_scl  = 1'b0;
                                nxt.drv_sda  = 1'b0;
                                nxt.phase    = PH_IDLE;
                                done         = 1'b1;
                            end
                        end else if (sda_in) begin
                            nxt.flag_nack = 1'b1;
                        end
                    end else if (cur.bit_count < BITS_PER_BYTE) begin
                        nxt.shift_reg = {cur.shift_reg[6:0], sda_in};
                    end
                    if (!done) begin
                        nxt.tick_timer = timer_load(cfg.clock_high_ticks);
                        nxt.phase      = PH_BIT_HIGH;
                    end
                end
            end
            PH_BIT_HIGH: begin
                if (cur.tick_timer == '0) begin
                    nxt.drv_scl = 1'b1;
                    if (cnt_inc <= BITS_PER_BYTE) begin
                        nxt.bit_count  = cnt_inc;
                        nxt.drv_sda    = bit_sda_pull(cur.active_cmd, cnt_inc, cur.shift_reg);
                        nxt.tick_timer = timer_load(cfg.clock_low_ticks);
                        nxt.phase      = PH_BIT_LOW;
                    end else begin
                        nxt.drv_sda   = 1'b0;
                        if (cur.active_cmd != CMD_WRITE) begin
                            nxt.last_read = cur.shift_reg;
                        end
                        nxt.bit_count = 4'd0;
                        nxt.phase     = PH_IDLE;
                        done          = 1'b1;
                    end
                end else begin
                    nxt.tick_timer = cur.tick_timer - TIMER_ONE;
                end
            end
            default: begin
                nxt.phase = PH_IDLE;
            end
        endcase
    end

endmodule
